// ----- rtl/core/smp_pkg.sv -----
// ----------------------------------------------------------------------------
// smp_pkg
// Shared widths, register indexes, types and helpers for the substring
// match block.
// ----------------------------------------------------------------------------
`default_nettype none

package smp_pkg;

    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 4;
    localparam int POS_W     = 16;
    localparam int PAT_W     = 64;
    localparam int CFG_IDX_W = 1;
    localparam int PSEL_W    = 3;   // selects one of the eight pattern bytes

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_LIMIT = 8'd127;
    localparam logic [POS_W-1:0]  COUNT_MAX  = 16'hFFFF;

    localparam logic [PAT_W-1:0] PATTERN_RESET = '0;
    localparam logic [LEN_W-1:0] LENGTH_RESET  = 4'd1;

    // Controls fanned out to every history cell.
    typedef struct packed {
        logic shift;   // character taken: every cell loads its neighbor
        logic brk;     // non-character taken: the run ends
    } t_cell_ctrl;

    typedef struct packed {
        logic [POS_W-1:0] match_start;
        logic [POS_W-1:0] match_end;
        logic [POS_W-1:0] occurrence_number;
    } t_result;

    function automatic logic is_char(input logic [CHAR_W-1:0] b);
        return (b != '0) && (b < CHAR_LIMIT);
    endfunction

    function automatic logic [CHAR_W-1:0] pattern_byte(input logic [PAT_W-1:0] pat,
                                                       input logic [PSEL_W-1:0] sel);
        return pat[sel*CHAR_W +: CHAR_W];
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + POS_W'(1);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/smp_in_if.sv -----
// ----------------------------------------------------------------------------
// smp_in_if
// Text byte channel: valid/ready handshake with one text byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface smp_in_if;
    logic                         valid;
    logic                         ready;
    logic [smp_pkg::CHAR_W-1:0]   text_byte;
    logic                         first_of_text;

    modport source (output valid, output text_byte, output first_of_text, input ready);
    modport sink   (input valid, input text_byte, input first_of_text, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/smp_out_if.sv -----
// ----------------------------------------------------------------------------
// smp_out_if
// Match result channel: valid/ready handshake, one match per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface smp_out_if;
    logic                        valid;
    logic                        ready;
    logic [smp_pkg::POS_W-1:0]   match_start;
    logic [smp_pkg::POS_W-1:0]   match_end;
    logic [smp_pkg::POS_W-1:0]   occurrence_number;

    modport source (output valid, output match_start, output match_end,
                    output occurrence_number, input ready);
    modport sink   (input valid, input match_start, input match_end,
                    input occurrence_number, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/smp_cell.sv -----
// ----------------------------------------------------------------------------
// smp_cell
// One history cell: holds one recent character and whether it belongs to
// the current unbroken run, and checks the incoming character against its
// pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module smp_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire smp_pkg::t_cell_ctrl          i_ctrl,
    input  wire logic [smp_pkg::CHAR_W-1:0]   i_char,
    input  wire logic                         i_valid,
    input  wire logic [smp_pkg::CHAR_W-1:0]   i_exp,
    input  wire logic                         i_en,
    output      logic [smp_pkg::CHAR_W-1:0]   o_char,
    output      logic                         o_valid,
    output      logic                         o_ok
);

    logic [smp_pkg::CHAR_W-1:0] r_char;
    logic                       r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_char <= i_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_valid;
        end else if (i_ctrl.brk) begin
            r_valid <= 1'b0;
        end
    end

    // Compare the value this cell takes on the shift, so the hit is known
    // in the same cycle as the byte.
    assign o_ok    = !i_en || (i_valid && (i_char == i_exp));
    assign o_char  = r_char;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ----- rtl/core/smp_out_stage.sv -----
// ----------------------------------------------------------------------------
// smp_out_stage
// Result register between the match logic and the result channel; the
// input side stalls while a result waits and is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module smp_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire smp_pkg::t_result   i_result,
    output      logic               o_ready,
    smp_out_if.source               o_match
);

    logic             r_valid;
    smp_pkg::t_result r_result;

    assign o_ready = !r_valid || o_match.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_match.valid             = r_valid;
    assign o_match.match_start       = r_result.match_start;
    assign o_match.match_end         = r_result.match_end;
    assign o_match.occurrence_number = r_result.occurrence_number;

endmodule

`default_nettype wire

// ----- rtl/core/substring_match_positions.sv -----
// A match is on o_match in the cycle after the transfer of its last byte.
// Throughput: one text byte per cycle; the history shifts through a row of
// cells and all pattern positions compare in parallel with the incoming byte.
// The single result register stalls input only while it is full and not taken.
// Reset (synchronous, active low): history run bits, position, count and the
// result register clear; pattern_chars returns to 0 and pattern_length to 1.
// ----------------------------------------------------------------------------
// substring_match_positions
// Streams text bytes and reports every, possibly overlapping, occurrence of
// a configured pattern of up to MAX_PATTERN characters.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_match_positions #(
    parameter int MAX_PATTERN = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [smp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [smp_pkg::PAT_W-1:0]        i_cfg_data,
    smp_in_if.sink                                i_text,
    smp_out_if.source                             o_match
);

    localparam logic [smp_pkg::LEN_W-1:0] MAX_LEN = smp_pkg::LEN_W'(MAX_PATTERN);

    logic [smp_pkg::PAT_W-1:0]  r_pattern;
    logic [smp_pkg::LEN_W-1:0]  r_len;
    logic [smp_pkg::POS_W-1:0]  r_pos;
    logic [smp_pkg::POS_W-1:0]  r_cnt;

    logic [smp_pkg::LEN_W-1:0]  len_eff;
    logic                       accept;
    logic                       stage_ready;
    logic                       smp_ready;
    logic                       byte_is_char;
    logic                       first;
    logic                       hit;
    logic [smp_pkg::POS_W-1:0]  pos_base;
    logic [smp_pkg::POS_W-1:0]  pos_next;
    logic [smp_pkg::POS_W-1:0]  cnt_base;
    logic [smp_pkg::POS_W-1:0]  cnt_next;
    smp_pkg::t_cell_ctrl        cell_ctrl;
    smp_pkg::t_result           result;

    logic [smp_pkg::CHAR_W-1:0] cell_char [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]     cell_valid;
    logic [MAX_PATTERN-1:0]     cell_ok;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= smp_pkg::PATTERN_RESET;
            r_len     <= smp_pkg::LENGTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smp_pkg::CFG_PATTERN_CHARS:  r_pattern <= i_cfg_data;
                smp_pkg::CFG_PATTERN_LENGTH: r_len     <= i_cfg_data[smp_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_eff = (r_len > MAX_LEN) ? MAX_LEN : r_len;

    assign stage_ready  = smp_ready;
    assign i_text.ready = stage_ready;
    assign accept       = i_text.valid && stage_ready;
    assign first        = i_text.first_of_text;
    assign byte_is_char = smp_pkg::is_char(i_text.text_byte);

    assign cell_ctrl.shift = accept && byte_is_char;
    assign cell_ctrl.brk   = accept && !byte_is_char;

    // Row of history cells; a new text clears the run bits moving down the row.
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        logic [smp_pkg::CHAR_W-1:0] in_char;
        logic                       in_valid;
        logic [smp_pkg::LEN_W-1:0]  pidx;

        if (g == 0) begin : g_head
            assign in_char  = i_text.text_byte;
            assign in_valid = 1'b1;
        end else begin : g_body
            assign in_char  = cell_char[g-1];
            assign in_valid = cell_valid[g-1] && !first;
        end

        // Cell g holds the character g places before the newest, which must
        // equal pattern byte len-1-g.
        assign pidx = len_eff - smp_pkg::LEN_W'(g) - smp_pkg::LEN_W'(1);

        smp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_char  (in_char),
            .i_valid (in_valid),
            .i_exp   (smp_pkg::pattern_byte(r_pattern, pidx[smp_pkg::PSEL_W-1:0])),
            .i_en    (smp_pkg::LEN_W'(g) < len_eff),
            .o_char  (cell_char[g]),
            .o_valid (cell_valid[g]),
            .o_ok    (cell_ok[g])
        );
    end

    assign hit = byte_is_char && (len_eff != '0) && (&cell_ok);

    assign pos_base = first ? '0 : r_pos;
    assign cnt_base = first ? '0 : r_cnt;
    assign pos_next = smp_pkg::sat_inc(pos_base);
    assign cnt_next = smp_pkg::sat_inc(cnt_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            r_pos <= byte_is_char ? pos_next : pos_base;
            r_cnt <= hit ? cnt_next : cnt_base;
        end
    end

    assign result.match_start       = pos_next - smp_pkg::POS_W'(len_eff)
                                      + smp_pkg::POS_W'(1);
    assign result.match_end         = pos_next;
    assign result.occurrence_number = cnt_next;

    smp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && hit),
        .i_result (result),
        .o_ready  (smp_ready),
        .o_match  (o_match)
    );

`ifndef SYNTH
    // Run bits form a contiguous run from the newest cell.
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("history run bits not contiguous");

    // A reported match never ends before it starts and is always counted.
    a_match_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_match.valid |-> (o_match.match_end >= o_match.match_start)
                          && (o_match.occurrence_number != '0))
        else $error("match positions or count inconsistent");

    // A result that turns valid needs a character byte accepted in the cycle before.
    a_match_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_match.valid) |-> $past(accept && byte_is_char))
        else $error("result without an accepted character");
`endif

endmodule

`default_nettype wire

// ----- test/substring_match_positions_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// substring_match_positions_tb
// Streams text bytes into the substring matcher and checks every reported
// match, field by field, against a cycle-free prediction of the
// start/end/count sequence. It covers a directed set of corner cases, random
// texts under changing patterns and an output hold-off that backs up the input.
// ----------------------------------------------------------------------------

module substring_match_positions_tb;

    localparam int MAX_PAT_LEN = 8;
    localparam int IDLE_PCT    = 38;
    localparam int SETTLE_CYC  = 4;
    localparam int HOLD_CYC    = 150;

    // Predicts matches from accepted text bytes and checks the block's results.
    class match_tracker;
        logic [smp_pkg::PAT_W-1:0]  pat_bytes;
        logic [smp_pkg::LEN_W-1:0]  pat_len;
        logic [smp_pkg::CHAR_W-1:0] history [MAX_PAT_LEN];
        logic [smp_pkg::LEN_W-1:0]  run_len;
        logic [smp_pkg::POS_W-1:0]  char_pos;
        logic [smp_pkg::POS_W-1:0]  hit_count;
        smp_pkg::t_result           pending_matches [$];
        int unsigned                fail_count;

        function new();
            pat_bytes  = smp_pkg::PATTERN_RESET;
            pat_len    = smp_pkg::LENGTH_RESET;
            fail_count = 0;
            clear_text();
        endfunction

        function void clear_text();
            int i;
            for (i = 0; i < MAX_PAT_LEN; i++) history[i] = '0;
            run_len   = '0;
            char_pos  = '0;
            hit_count = '0;
        endfunction

        function void write_reg(logic [smp_pkg::CFG_IDX_W-1:0] idx,
                                logic [smp_pkg::PAT_W-1:0] data);
            if (idx == smp_pkg::CFG_PATTERN_CHARS) begin
                pat_bytes = data;
            end else begin
                pat_len = data[smp_pkg::LEN_W-1:0];
            end
        endfunction

        function void note_fail(string msg);
            fail_count++;
            if (fail_count <= 10) $display("%0t: %s", $time, msg);
        endfunction

        function void take_byte(logic [smp_pkg::CHAR_W-1:0] b, logic first);
            int               i;
            int               eff_len;
            bit               hit;
            smp_pkg::t_result r;
            if (first) clear_text();
            // non-character: run breaks, no position taken
            if (b == '0 || b >= smp_pkg::CHAR_LIMIT) begin
                run_len = '0;
                return;
            end
            for (i = MAX_PAT_LEN - 1; i > 0; i--) history[i] = history[i-1];
            history[0] = b;
            if (run_len < MAX_PAT_LEN) run_len++;
            if (char_pos != smp_pkg::COUNT_MAX) char_pos++;
            eff_len = (pat_len > MAX_PAT_LEN) ? MAX_PAT_LEN : int'(pat_len);
            if (eff_len == 0 || run_len < eff_len) return;
            hit = 1'b1;
            for (i = 0; i < eff_len; i++) begin
                if (history[i] != pat_bytes[(eff_len - 1 - i)*smp_pkg::CHAR_W +: smp_pkg::CHAR_W])
                    hit = 1'b0;
            end
            if (!hit) return;
            if (hit_count != smp_pkg::COUNT_MAX) hit_count++;
            r.match_start       = smp_pkg::POS_W'(char_pos - eff_len + 1);
            r.match_end         = char_pos;
            r.occurrence_number = hit_count;
            pending_matches.push_back(r);
        endfunction

        function void check_match(smp_pkg::t_result got);
            smp_pkg::t_result want;
            bit               bad;
            if (pending_matches.size() == 0) begin
                note_fail($sformatf("unexpected match: start %0d end %0d occurrence %0d",
                                    got.match_start, got.match_end, got.occurrence_number));
                return;
            end
            want = pending_matches.pop_front();
            bad  = 1'b0;
            if (got.match_start !== want.match_start) bad = 1'b1;
            if (got.match_end !== want.match_end) bad = 1'b1;
            if (got.occurrence_number !== want.occurrence_number) bad = 1'b1;
            if (bad) begin
                note_fail($sformatf({"match mismatch: expected start %0d end %0d occ %0d,",
                                     " got start %0d end %0d occ %0d"},
                                    want.match_start, want.match_end,
                                    want.occurrence_number, got.match_start,
                                    got.match_end, got.occurrence_number));
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [smp_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [smp_pkg::PAT_W-1:0]     cfg_data;

    smp_in_if  text_if ();
    smp_out_if match_if ();

    match_tracker tracker;
    bit           src_idle_on   = 1'b1;
    bit           sink_idle_on  = 1'b1;
    bit           stall_request = 1'b0;

    substring_match_positions #(
        .MAX_PATTERN (MAX_PAT_LEN)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_text     (text_if),
        .o_match    (match_if)
    );

    always #5 i_clk = ~i_clk;

    // Monitor: both channels sampled right after the edge, before any update lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (match_if.valid && match_if.ready) begin
                tracker.check_match(smp_pkg::t_result'({match_if.match_start,
                                                        match_if.match_end,
                                                        match_if.occurrence_number}));
            end
            if (text_if.valid && text_if.ready) begin
                tracker.take_byte(text_if.text_byte, text_if.first_of_text);
            end
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        match_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                match_if.ready <= 1'b0;
            end else if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = HOLD_CYC;
                match_if.ready <= 1'b0;
            end else begin
                match_if.ready <= !(sink_idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        #10ms;
        $display("simulation failed");
        $finish;
    end

    task automatic send_byte(input logic [smp_pkg::CHAR_W-1:0] b, input logic first);
        if (src_idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                text_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        text_if.valid         <= 1'b1;
        text_if.text_byte     <= b;
        text_if.first_of_text <= first;
        @(posedge i_clk);
        while (!text_if.ready) @(posedge i_clk);
    endtask

    // Wait until every predicted match has come out, then let the pipe settle.
    task automatic drain();
        text_if.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_matches.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic load_pattern(input logic [smp_pkg::PAT_W-1:0] chars,
                                input logic [smp_pkg::LEN_W-1:0] len);
        logic [smp_pkg::PAT_W-1:0] len_word;
        len_word          = {$urandom, $urandom};
        len_word[smp_pkg::LEN_W-1:0] = len;
        cfg_we   <= 1'b1;
        cfg_idx  <= smp_pkg::CFG_PATTERN_CHARS;
        cfg_data <= chars;
        @(posedge i_clk);
        cfg_idx  <= smp_pkg::CFG_PATTERN_LENGTH;
        cfg_data <= len_word;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        tracker.write_reg(smp_pkg::CFG_PATTERN_CHARS, chars);
        tracker.write_reg(smp_pkg::CFG_PATTERN_LENGTH, len_word);
    endtask

    task automatic send_string(input string s, input logic first);
        int k;
        for (k = 0; k < s.len(); k++) send_byte(s[k], first && k == 0);
    endtask

    function automatic logic [smp_pkg::CHAR_W-1:0] pick_pattern_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return smp_pkg::CHAR_W'(8'h61 + $urandom_range(0, 2));
        if (r < 87) return 8'h01;
        if (r < 94) return 8'h7E;
        return smp_pkg::CHAR_W'($urandom_range(1, 126));
    endfunction

    // Mostly pattern material so matches are frequent; some other characters and breaks.
    task automatic send_random_chunk(inout int sent);
        int                         r;
        int                         k;
        int                         plen;
        int                         sel;
        logic                       first;
        logic [smp_pkg::CHAR_W-1:0] b;
        plen  = (tracker.pat_len > MAX_PAT_LEN) ? MAX_PAT_LEN : int'(tracker.pat_len);
        r     = $urandom_range(0, 99);
        first = ($urandom_range(0, 99) < 2);
        if (r < 20 && plen > 0) begin
            for (k = 0; k < plen; k++) begin
                send_byte(tracker.pat_bytes[k*smp_pkg::CHAR_W +: smp_pkg::CHAR_W],
                          first && k == 0);
                sent++;
            end
        end else begin
            if (r < 80) begin
                sel = $urandom_range(0, (plen == 0) ? MAX_PAT_LEN - 1 : plen - 1);
                b   = tracker.pat_bytes[sel*smp_pkg::CHAR_W +: smp_pkg::CHAR_W];
            end else if (r < 92) begin
                b = smp_pkg::CHAR_W'($urandom_range(1, 126));
            end else if (r < 95) begin
                b = 8'h00;
            end else begin
                b = smp_pkg::CHAR_W'($urandom_range(127, 255));
            end
            send_byte(b, first);
            sent++;
        end
    endtask

    initial begin : stimulus
        int                        ph;
        int                        k;
        int                        sent;
        logic [smp_pkg::PAT_W-1:0] chars;
        logic [smp_pkg::LEN_W-1:0] len;

        tracker = new();
        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= smp_pkg::CFG_PATTERN_CHARS;
        cfg_data              <= '0;
        text_if.valid         <= 1'b0;
        text_if.text_byte     <= '0;
        text_if.first_of_text <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset pattern (all zero bytes) never matches; character extremes and breaks.
        send_byte(8'h01, 1'b1);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        drain();

        // Repeated hits and a break inside a partial match.
        load_pattern(64'hFFFF_FFFF_FFFF_6261, 4'd2);
        send_string("abab", 1'b1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h62, 1'b0);
        drain();

        // Zero length never matches.
        load_pattern(64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        send_string("aa", 1'b0);
        drain();

        // Length above the maximum behaves as a full-length pattern.
        load_pattern(64'h4645_4443_4241_7E01, 4'd15);
        send_byte(8'h01, 1'b1);
        send_string({8'h7E, "ABCDEF"}, 1'b0);
        drain();

        // A pattern byte outside the character range can never match.
        load_pattern(64'h0000_0000_0000_8061, 4'd2);
        send_byte(8'h61, 1'b0);
        send_byte(8'h80, 1'b0);
        drain();

        // Result side held off while every byte matches: the input must stall.
        load_pattern(64'h0000_0000_0000_0078, 4'd1);
        src_idle_on   = 1'b0;
        stall_request = 1'b1;
        for (k = 0; k < 40; k++) send_byte(8'h78, k == 0);
        src_idle_on = 1'b1;
        drain();

        for (ph = 0; ph < 10; ph++) begin
            drain();
            src_idle_on  = (ph != 4);
            sink_idle_on = (ph != 4);
            for (k = 0; k < MAX_PAT_LEN; k++)
                chars[k*smp_pkg::CHAR_W +: smp_pkg::CHAR_W] = pick_pattern_char();
            if ($urandom_range(0, 99) < 10) begin
                len = ($urandom_range(0, 1) == 0) ? 4'd0
                                                  : smp_pkg::LEN_W'($urandom_range(9, 15));
            end else begin
                len = smp_pkg::LEN_W'($urandom_range(1, MAX_PAT_LEN));
            end
            if (ph == 0) len = 4'd1;
            if (ph == 1) len = 4'd8;
            if (ph == 9) chars = {$urandom, $urandom};
            load_pattern(chars, len);
            sent = 0;
            while (sent < 163) send_random_chunk(sent);
        end
        drain();

        if (tracker.pending_matches.size() != 0) begin
            tracker.note_fail($sformatf("%0d expected matches never arrived",
                                        tracker.pending_matches.size()));
        end
        if (tracker.fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
